// ===== src/qov_pkg.sv =====
package qov_pkg;

  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int NUM_Q           = 10;
  localparam int COORD_W         = 32;
  localparam int ERR_W           = 48;
  localparam int FRAC_W          = 16;
  localparam int THR_W           = 32;
  localparam int QUO_W           = COORD_W + 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [ERR_W-1:0]   ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0]   ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};

  // Slots of the quadric entries in the flat entry bus
  localparam int Q00 = 0;
  localparam int Q01 = 1;
  localparam int Q02 = 2;
  localparam int Q03 = 3;
  localparam int Q11 = 4;
  localparam int Q12 = 5;
  localparam int Q13 = 6;
  localparam int Q22 = 7;
  localparam int Q23 = 8;
  localparam int Q33 = 9;

  typedef struct packed {
    logic       valid;
    logic       fail;
    logic [2:0] neg;
  } qov_ctl_t;

  // Determinant and Cramer numerator width
  function automatic int det_w(input int ew);
    return 3 * ew + 3;
  endfunction

  // Divider datapath width: numerator scaled by 2^17, divisor scaled by 2^33
  function automatic int div_w(input int ew);
    return 3 * ew + 38;
  endfunction

endpackage

// ===== src/qov_if.sv =====
interface qov_in_if #(parameter int ENTRY_WIDTH = qov_pkg::ENTRY_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [ENTRY_WIDTH-1:0] q00;
  logic signed [ENTRY_WIDTH-1:0] q01;
  logic signed [ENTRY_WIDTH-1:0] q02;
  logic signed [ENTRY_WIDTH-1:0] q03;
  logic signed [ENTRY_WIDTH-1:0] q11;
  logic signed [ENTRY_WIDTH-1:0] q12;
  logic signed [ENTRY_WIDTH-1:0] q13;
  logic signed [ENTRY_WIDTH-1:0] q22;
  logic signed [ENTRY_WIDTH-1:0] q23;
  logic signed [ENTRY_WIDTH-1:0] q33;

  modport source (output valid, q00, q01, q02, q03, q11, q12, q13, q22, q23, q33,
                  input ready);
  modport sink (input valid, q00, q01, q02, q03, q11, q12, q13, q22, q23, q33,
                output ready);
endinterface

interface qov_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    solved;
  logic signed [qov_pkg::COORD_W-1:0]      pos_x;
  logic signed [qov_pkg::COORD_W-1:0]      pos_y;
  logic signed [qov_pkg::COORD_W-1:0]      pos_z;
  logic signed [qov_pkg::ERR_W-1:0]        quad_error;

  modport source (output valid, solved, pos_x, pos_y, pos_z, quad_error, input ready);
  modport sink (input valid, solved, pos_x, pos_y, pos_z, quad_error, output ready);
endinterface

// ===== src/quadric_optimal_vertex_solve_core.sv =====
// Optimal vertex of a symmetric 4x4 edge quadric.
// Requests arrive on the quad channel (valid/ready) carrying the ten
// upper-triangle entries in signed Q16.16. Results leave on the vertex
// channel: solved flag, position x/y/z in Q16.16 and the quadric error in
// Q32.16, all saturated; a failed solve gives zeros with solved low.
// cfg_we/cfg_wdata write det_threshold (unsigned Q16.16); write it only
// while no request is in flight. The solve fails when |det| is zero or below it.
// An accepted request passes through cofactor and determinant math,
// restoring division (one quotient bit per stage for all three
// coordinates) and error evaluation. One request is taken every cycle while
// the output is not stalled; the whole pipeline advances together
// whenever the output register is empty or drained.
// When the receiver stalls, every stage holds and quad.ready drops.
// Reset clears all valid bits and loads det_threshold with 7.
module quadric_optimal_vertex_solve_core #(
  parameter int ENTRY_WIDTH = qov_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [qov_pkg::THR_W-1:0]   cfg_wdata,
  qov_in_if.sink                      quad,
  qov_out_if.source                   vertex
);

  localparam int EW = ENTRY_WIDTH;
  localparam int RW = qov_pkg::div_w(EW);

  logic                               en;
  logic [qov_pkg::THR_W-1:0]          thr;
  logic [qov_pkg::NUM_Q*EW-1:0]       q_flat;
  qov_pkg::qov_ctl_t                  ctl_cr;
  logic [RW-1:0]                      num [3];
  logic [RW-1:0]                      den;
  logic [qov_pkg::NUM_Q*EW-1:0]       q_cr;
  qov_pkg::qov_ctl_t                  ctl_dv;
  logic signed [qov_pkg::COORD_W-1:0] pos [3];
  logic [qov_pkg::NUM_Q*EW-1:0]       q_dv;

  assign en         = !vertex.valid || vertex.ready;
  assign quad.ready = en;

  assign q_flat = {quad.q33, quad.q23, quad.q22, quad.q13, quad.q12,
                   quad.q11, quad.q03, quad.q02, quad.q01, quad.q00};

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= qov_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  qov_cramer #(.EW(EW)) u_cramer (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (quad.valid),
    .q_in     (q_flat),
    .thr      (thr),
    .ctl      (ctl_cr),
    .num      (num),
    .den      (den),
    .q_out    (q_cr)
  );

  qov_div #(.EW(EW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_cr),
    .num     (num),
    .den     (den),
    .q_in    (q_cr),
    .ctl_out (ctl_dv),
    .pos     (pos),
    .q_out   (q_dv)
  );

  qov_err #(.EW(EW)) u_err (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .ctl_in     (ctl_dv),
    .pos        (pos),
    .q_in       (q_dv),
    .valid      (vertex.valid),
    .solved     (vertex.solved),
    .pos_x      (vertex.pos_x),
    .pos_y      (vertex.pos_y),
    .pos_z      (vertex.pos_z),
    .quad_error (vertex.quad_error)
  );

`ifndef SYNTH
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    vertex.valid && !vertex.solved |-> vertex.pos_x == '0 && vertex.pos_y == '0 &&
      vertex.pos_z == '0 && vertex.quad_error == '0)
    else $error("failed solve with nonzero result");

  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    vertex.valid && !vertex.ready |-> !quad.ready)
    else $error("request taken while result stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !vertex.valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== src/qov_mulw.sv =====
module qov_mulw #(
  parameter int AW = 32,
  parameter int BW = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  localparam int LW = BW / 2;
  localparam int HW = BW - LW;

  logic signed [AW+LW:0]   p_lo;
  logic signed [AW+HW-1:0] p_hi;

  // Two partial products, then combine
  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= a * $signed({1'b0, b[LW-1:0]});
      p_hi <= a * $signed(b[BW-1:LW]);
      p    <= {p_hi, {LW{1'b0}}} + (AW+BW)'(p_lo);
    end
  end

endmodule

// ===== src/qov_cramer.sv =====
module qov_cramer #(
  parameter int EW = qov_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [qov_pkg::NUM_Q*EW-1:0]      q_in,
  input  logic [qov_pkg::THR_W-1:0]         thr,
  output qov_pkg::qov_ctl_t                 ctl,
  output logic [qov_pkg::div_w(EW)-1:0]     num [3],
  output logic [qov_pkg::div_w(EW)-1:0]     den,
  output logic [qov_pkg::NUM_Q*EW-1:0]      q_out
);

  localparam int PW  = 2 * EW;
  localparam int CW  = 2 * EW + 1;
  localparam int MW  = 3 * EW + 1;
  localparam int DW  = qov_pkg::det_w(EW);
  localparam int RW  = qov_pkg::div_w(EW);
  localparam int TXW = qov_pkg::THR_W + 2 * qov_pkg::FRAC_W;

  logic [6:1]              vld;
  logic signed [EW-1:0]    qs [1:6][qov_pkg::NUM_Q];
  logic signed [PW-1:0]    pr [12];
  logic signed [CW-1:0]    cf [3];
  logic signed [CW-1:0]    pp [3];
  logic signed [EW-1:0]    ma [12];
  logic signed [CW-1:0]    mb [12];
  logic signed [MW-1:0]    mp [12];
  logic signed [DW-1:0]    sm [4];
  logic [DW-1:0]           det_abs;
  logic [DW-1:0]           num_abs [3];
  logic                    fail_c;
  logic [2:0]              neg_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < qov_pkg::NUM_Q; i++) begin
        qs[1][i] <= $signed(q_in[i*EW +: EW]);
      end
      for (int s = 2; s <= 6; s++) begin
        for (int i = 0; i < qov_pkg::NUM_Q; i++) begin
          qs[s][i] <= qs[s-1][i];
        end
      end
    end
  end

  // Second-order minors
  always_ff @(posedge clk) begin
    if (en) begin
      pr[0]  <= qs[1][qov_pkg::Q11] * qs[1][qov_pkg::Q22];
      pr[1]  <= qs[1][qov_pkg::Q12] * qs[1][qov_pkg::Q12];
      pr[2]  <= qs[1][qov_pkg::Q02] * qs[1][qov_pkg::Q12];
      pr[3]  <= qs[1][qov_pkg::Q01] * qs[1][qov_pkg::Q22];
      pr[4]  <= qs[1][qov_pkg::Q01] * qs[1][qov_pkg::Q12];
      pr[5]  <= qs[1][qov_pkg::Q11] * qs[1][qov_pkg::Q02];
      pr[6]  <= qs[1][qov_pkg::Q03] * qs[1][qov_pkg::Q01];
      pr[7]  <= qs[1][qov_pkg::Q00] * qs[1][qov_pkg::Q13];
      pr[8]  <= qs[1][qov_pkg::Q00] * qs[1][qov_pkg::Q23];
      pr[9]  <= qs[1][qov_pkg::Q03] * qs[1][qov_pkg::Q02];
      pr[10] <= qs[1][qov_pkg::Q13] * qs[1][qov_pkg::Q02];
      pr[11] <= qs[1][qov_pkg::Q01] * qs[1][qov_pkg::Q23];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cf[k] <= CW'(pr[2*k]) - CW'(pr[2*k+1]);
        pp[k] <= CW'(pr[2*k+6]) - CW'(pr[2*k+7]);
      end
    end
  end

  // det, then the x, y and z numerators
  always_comb begin
    ma[0]  = qs[3][qov_pkg::Q00];  mb[0]  = cf[0];
    ma[1]  = qs[3][qov_pkg::Q01];  mb[1]  = cf[1];
    ma[2]  = qs[3][qov_pkg::Q02];  mb[2]  = cf[2];
    ma[3]  = qs[3][qov_pkg::Q03];  mb[3]  = cf[0];
    ma[4]  = qs[3][qov_pkg::Q13];  mb[4]  = cf[1];
    ma[5]  = qs[3][qov_pkg::Q23];  mb[5]  = cf[2];
    ma[6]  = qs[3][qov_pkg::Q22];  mb[6]  = pp[0];
    ma[7]  = qs[3][qov_pkg::Q12];  mb[7]  = pp[1];
    ma[8]  = qs[3][qov_pkg::Q02];  mb[8]  = pp[2];
    ma[9]  = qs[3][qov_pkg::Q12];  mb[9]  = pp[0];
    ma[10] = qs[3][qov_pkg::Q11];  mb[10] = pp[1];
    ma[11] = qs[3][qov_pkg::Q01];  mb[11] = pp[2];
  end

  for (genvar m = 0; m < 12; m++) begin : g_mul
    qov_mulw #(.AW(EW), .BW(CW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma[m]),
      .b   (mb[m]),
      .p   (mp[m])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sm[k] <= DW'(mp[3*k]) + DW'(mp[3*k+1]) + DW'(mp[3*k+2]);
      end
    end
  end

  always_comb begin
    det_abs = sm[0][DW-1] ? DW'(-sm[0]) : DW'(sm[0]);
    for (int k = 0; k < 3; k++) begin
      num_abs[k] = sm[k+1][DW-1] ? DW'(-sm[k+1]) : DW'(sm[k+1]);
    end
    fail_c = (sm[0] == '0) ||
             ({{TXW{1'b0}}, det_abs} <
              {{DW{1'b0}}, thr, {(2*qov_pkg::FRAC_W){1'b0}}});
    // x and z carry the minus sign of -A^-1 b
    neg_c[0] = ~(sm[1][DW-1] ^ sm[0][DW-1]);
    neg_c[1] = sm[2][DW-1] ^ sm[0][DW-1];
    neg_c[2] = ~(sm[3][DW-1] ^ sm[0][DW-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid <= vld[6];
      ctl.fail  <= fail_c;
      ctl.neg   <= neg_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num[k] <= (RW'(num_abs[k]) << (qov_pkg::FRAC_W + 1)) + RW'(det_abs);
      end
      den <= RW'(det_abs) << 1;
      for (int i = 0; i < qov_pkg::NUM_Q; i++) begin
        q_out[i*EW +: EW] <= qs[6][i];
      end
    end
  end

endmodule

// ===== src/qov_div.sv =====
module qov_div #(
  parameter int EW = qov_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  qov_pkg::qov_ctl_t                  ctl_in,
  input  logic [qov_pkg::div_w(EW)-1:0]      num [3],
  input  logic [qov_pkg::div_w(EW)-1:0]      den,
  input  logic [qov_pkg::NUM_Q*EW-1:0]       q_in,
  output qov_pkg::qov_ctl_t                  ctl_out,
  output logic signed [qov_pkg::COORD_W-1:0] pos [3],
  output logic [qov_pkg::NUM_Q*EW-1:0]       q_out
);

  localparam int RW = qov_pkg::div_w(EW);
  localparam int QW = qov_pkg::QUO_W;
  localparam int CW = qov_pkg::COORD_W;

  logic [RW-1:0]              rem [0:QW][3];
  logic [QW-1:0]              quo [0:QW][3];
  logic [RW-1:0]              dv  [0:QW];
  logic [2:0]                 ovf [0:QW];
  qov_pkg::qov_ctl_t          cs  [0:QW];
  logic [qov_pkg::NUM_Q*EW-1:0] qb [0:QW];
  logic signed [CW-1:0]       pos_c [3];

  // Entry stage: flag quotients that cannot fit QW bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cs[0] <= '0;
    end else if (en) begin
      cs[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= num[l];
        quo[0][l] <= '0;
        ovf[0][l] <= num[l] >= (den << QW);
      end
      dv[0] <= den;
      qb[0] <= q_in;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int K = QW - 1 - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        cs[s+1] <= '0;
      end else if (en) begin
        cs[s+1] <= cs[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (rem[s][l] >= (dv[s] << K)) begin
            rem[s+1][l] <= rem[s][l] - (dv[s] << K);
            quo[s+1][l] <= {quo[s][l][QW-2:0], 1'b1};
          end else begin
            rem[s+1][l] <= rem[s][l];
            quo[s+1][l] <= {quo[s][l][QW-2:0], 1'b0};
          end
        end
        dv[s+1]  <= dv[s];
        ovf[s+1] <= ovf[s];
        qb[s+1]  <= qb[s];
      end
    end
  end

  // Apply sign and clamp to the coordinate range
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (cs[QW].neg[l]) begin
        if (ovf[QW][l] || quo[QW][l][QW-1] ||
            (quo[QW][l][QW-2] && (|quo[QW][l][QW-3:0]))) begin
          pos_c[l] = qov_pkg::COORD_MIN;
        end else begin
          pos_c[l] = -$signed(quo[QW][l][CW-1:0]);
        end
      end else begin
        if (ovf[QW][l] || quo[QW][l][QW-1] || quo[QW][l][QW-2]) begin
          pos_c[l] = qov_pkg::COORD_MAX;
        end else begin
          pos_c[l] = $signed(quo[QW][l][CW-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= cs[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos   <= pos_c;
      q_out <= qb[QW];
    end
  end

endmodule

// ===== src/qov_err.sv =====
module qov_err #(
  parameter int EW = qov_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  qov_pkg::qov_ctl_t                  ctl_in,
  input  logic signed [qov_pkg::COORD_W-1:0] pos [3],
  input  logic [qov_pkg::NUM_Q*EW-1:0]       q_in,
  output logic                               valid,
  output logic                               solved,
  output logic signed [qov_pkg::COORD_W-1:0] pos_x,
  output logic signed [qov_pkg::COORD_W-1:0] pos_y,
  output logic signed [qov_pkg::COORD_W-1:0] pos_z,
  output logic signed [qov_pkg::ERR_W-1:0]   quad_error
);

  localparam int CW  = qov_pkg::COORD_W;
  localparam int SQW = 2 * CW;
  localparam int LNW = EW + CW;
  localparam int LSW = EW + CW + 2;
  localparam int TW  = EW + SQW;
  localparam int SW  = EW + 70;
  localparam int SH  = 2 * qov_pkg::FRAC_W;
  localparam int EW_ = qov_pkg::ERR_W;

  qov_pkg::qov_ctl_t    cs [1:5];
  logic signed [CW-1:0] pc [1:5][3];
  logic signed [SQW-1:0] sq [6];
  logic signed [LNW-1:0] ln [3];
  logic signed [EW-1:0]  qa [6];
  logic signed [EW-1:0]  q33 [1:3];
  logic signed [LSW-1:0] lin [2:3];
  logic signed [TW-1:0]  tp [6];
  logic signed [SW-1:0]  sa;
  logic signed [SW-1:0]  sb;
  logic signed [SW-1:0]  sc;
  logic signed [SW-1:0]  s5;
  logic signed [SW-1:0]  s_shr;
  logic [SW-EW_:0]       top;
  logic                  over;
  logic signed [EW_-1:0] err_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 5; s++) begin
        cs[s] <= '0;
      end
      valid <= 1'b0;
    end else if (en) begin
      cs[1] <= ctl_in;
      for (int s = 2; s <= 5; s++) begin
        cs[s] <= cs[s-1];
      end
      valid <= cs[5].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc[1] <= pos;
      for (int s = 2; s <= 5; s++) begin
        pc[s] <= pc[s-1];
      end
    end
  end

  // Coordinate pair products and linear terms
  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= pos[0] * pos[0];
      sq[1] <= pos[1] * pos[1];
      sq[2] <= pos[2] * pos[2];
      sq[3] <= pos[0] * pos[1];
      sq[4] <= pos[0] * pos[2];
      sq[5] <= pos[1] * pos[2];
      ln[0] <= $signed(q_in[qov_pkg::Q03*EW +: EW]) * pos[0];
      ln[1] <= $signed(q_in[qov_pkg::Q13*EW +: EW]) * pos[1];
      ln[2] <= $signed(q_in[qov_pkg::Q23*EW +: EW]) * pos[2];
      qa[0] <= $signed(q_in[qov_pkg::Q00*EW +: EW]);
      qa[1] <= $signed(q_in[qov_pkg::Q11*EW +: EW]);
      qa[2] <= $signed(q_in[qov_pkg::Q22*EW +: EW]);
      qa[3] <= $signed(q_in[qov_pkg::Q01*EW +: EW]);
      qa[4] <= $signed(q_in[qov_pkg::Q02*EW +: EW]);
      qa[5] <= $signed(q_in[qov_pkg::Q12*EW +: EW]);
      q33[1] <= $signed(q_in[qov_pkg::Q33*EW +: EW]);
      q33[2] <= q33[1];
      q33[3] <= q33[2];
      lin[2] <= LSW'(ln[0]) + LSW'(ln[1]) + LSW'(ln[2]);
      lin[3] <= lin[2];
    end
  end

  for (genvar m = 0; m < 6; m++) begin : g_mul
    qov_mulw #(.AW(EW), .BW(SQW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (qa[m]),
      .b   (sq[m]),
      .p   (tp[m])
    );
  end

  // Square terms, doubled cross terms, and the linear plus constant part
  always_ff @(posedge clk) begin
    if (en) begin
      sa <= SW'(tp[0]) + SW'(tp[1]) + SW'(tp[2]);
      sb <= (SW'(tp[3]) + SW'(tp[4]) + SW'(tp[5])) <<< 1;
      sc <= (SW'(lin[3]) <<< (qov_pkg::FRAC_W + 1)) + (SW'(q33[3]) <<< SH) +
            (SW'(1) <<< (SH - 1));
      s5 <= sa + sb + sc;
    end
  end

  always_comb begin
    s_shr = s5 >>> SH;
    top   = s_shr[SW-1:EW_-1];
    over  = !((&top) || !(|top));
    if (over) begin
      err_sat = s_shr[SW-1] ? qov_pkg::ERR_MIN : qov_pkg::ERR_MAX;
    end else begin
      err_sat = s_shr[EW_-1:0];
    end
  end

  // Drop everything on a failed solve
  always_ff @(posedge clk) begin
    if (en) begin
      solved     <= !cs[5].fail;
      pos_x      <= cs[5].fail ? '0 : pc[5][0];
      pos_y      <= cs[5].fail ? '0 : pc[5][1];
      pos_z      <= cs[5].fail ? '0 : pc[5][2];
      quad_error <= cs[5].fail ? '0 : err_sat;
    end
  end

endmodule

// ===== bench/quadric_optimal_vertex_solve_core_tb.sv =====
`timescale 1ns / 100ps

module quadric_optimal_vertex_solve_core_tb;

  localparam int EW = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE = 60;
  localparam int ONE = 65536;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [EW-1:0] q00, q01, q02, q03, q11, q12, q13, q22, q23, q33;
  } quadric_t;

  typedef struct packed {
    logic                                solved;
    logic signed [qov_pkg::COORD_W-1:0]  pos_x;
    logic signed [qov_pkg::COORD_W-1:0]  pos_y;
    logic signed [qov_pkg::COORD_W-1:0]  pos_z;
    logic signed [qov_pkg::ERR_W-1:0]    quad_error;
  } vertex_t;

  typedef struct {
    quadric_t q;
    bit       typed;
    vertex_t  v;
  } quad_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [qov_pkg::THR_W-1:0] cfg_wdata = '0;

  qov_in_if #(.ENTRY_WIDTH(EW)) quad_ch ();
  qov_out_if vertex_ch ();

  quadric_optimal_vertex_solve_core #(.ENTRY_WIDTH(EW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .quad      (quad_ch),
    .vertex    (vertex_ch)
  );

  always #5 clk = ~clk;

  logic [qov_pkg::THR_W-1:0] det_thr = qov_pkg::THR_RESET;
  vertex_t pending_vertices[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  function automatic wide_t clamp(wide_t a, int w);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (a > hi) return hi;
    if (a < lo) return lo;
    return a;
  endfunction

  // round(num * 2^16 / den), ties away from zero
  function automatic wide_t cramer_coord(wide_t num, wide_t den, bit negate);
    bit neg;
    wide_t an, ad, qq;
    neg = ((num < 0) != (den < 0)) != negate;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    qq = ((an <<< 17) + ad) / (ad <<< 1);
    if (neg) qq = -qq;
    return clamp(qq, 32);
  endfunction

  function automatic vertex_t solve_vertex(quadric_t q, logic [qov_pkg::THR_W-1:0] thr);
    wide_t a00, a01, a02, b0, a11, a12, b1, a22, b2, c;
    wide_t c0, c1, c2, det, adet, p0, p1, p2, nx, ny, nz, x, y, z, s, lin;
    vertex_t v;
    a00 = q.q00; a01 = q.q01; a02 = q.q02; b0 = q.q03; a11 = q.q11;
    a12 = q.q12; b1 = q.q13; a22 = q.q22; b2 = q.q23; c = q.q33;
    v = '0;
    c0 = a11 * a22 - a12 * a12;
    c1 = a02 * a12 - a01 * a22;
    c2 = a01 * a12 - a11 * a02;
    det = a00 * c0 + a01 * c1 + a02 * c2;
    adet = (det < 0) ? -det : det;
    if (det == 0 || adet < (wide_t'(thr) <<< 32)) return v;
    p0 = b0 * a01 - a00 * b1;
    p1 = a00 * b2 - b0 * a02;
    p2 = b1 * a02 - a01 * b2;
    nx = b0 * c0 + b1 * c1 + b2 * c2;
    ny = a22 * p0 + a12 * p1 + a02 * p2;
    nz = a12 * p0 + a11 * p1 + a01 * p2;
    x = cramer_coord(nx, det, 1'b1);
    y = cramer_coord(ny, det, 1'b0);
    z = cramer_coord(nz, det, 1'b1);
    s = a00 * x * x + a11 * y * y + a22 * z * z
      + 2 * a01 * x * y + 2 * a02 * x * z + 2 * a12 * y * z;
    lin = 2 * (b0 * x + b1 * y + b2 * z);
    s = s + (lin <<< 16) + (c <<< 32) + (wide_t'(1) <<< 31);
    s = clamp(s >>> 32, 48);
    v.solved = 1'b1;
    v.pos_x = x[31:0];
    v.pos_y = y[31:0];
    v.pos_z = z[31:0];
    v.quad_error = s[47:0];
    return v;
  endfunction

  function automatic quadric_t mk_quad(int d0, int d1, int d2, int b0, int b1, int b2,
                                      int o01, int o02, int o12, int cc);
    quadric_t q;
    q.q00 = d0; q.q11 = d1; q.q22 = d2;
    q.q03 = b0; q.q13 = b1; q.q23 = b2;
    q.q01 = o01; q.q02 = o02; q.q12 = o12; q.q33 = cc;
    return q;
  endfunction

  function automatic logic signed [EW-1:0] rnd_small(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic quadric_t rand_quad();
    quadric_t q;
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1: begin
        q = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      2, 3, 4: begin
        q = mk_quad(rnd_small(8 * ONE), rnd_small(8 * ONE), rnd_small(8 * ONE),
                    rnd_small(64 * ONE), rnd_small(64 * ONE), rnd_small(64 * ONE),
                    rnd_small(4 * ONE), rnd_small(4 * ONE), rnd_small(4 * ONE),
                    rnd_small(256 * ONE));
      end
      5, 6: begin
        // well-conditioned: strong diagonal, weak coupling
        q = mk_quad($urandom_range(ONE, 32 * ONE), $urandom_range(ONE, 32 * ONE),
                    $urandom_range(ONE, 32 * ONE), rnd_small(1 << 24),
                    rnd_small(1 << 24), rnd_small(1 << 24), rnd_small(ONE / 4),
                    rnd_small(ONE / 4), rnd_small(ONE / 4), rnd_small(1 << 28));
      end
      7: begin
        // rank-one A: determinant is zero
        q = mk_quad(0, 0, 0, rnd_small(ONE), rnd_small(ONE), rnd_small(ONE), 0, 0, 0,
                    rnd_small(ONE));
        q.q00 = rnd_small(4 * ONE);
        q.q11 = q.q00; q.q22 = q.q00; q.q01 = q.q00; q.q02 = q.q00; q.q12 = q.q00;
      end
      8: begin
        // tiny determinant: below any nonzero threshold
        q = mk_quad(rnd_small(24), rnd_small(24), rnd_small(24), rnd_small(1 << 20),
                    rnd_small(1 << 20), rnd_small(1 << 20), rnd_small(4),
                    rnd_small(4), rnd_small(4), rnd_small(1 << 20));
      end
      default: begin
        // tiny diagonal, large linear part: coordinates saturate
        q = mk_quad($urandom_range(1, 3) << 16, rnd_small(1 << 10), rnd_small(ONE),
                    $urandom, $urandom, $urandom, 0, rnd_small(ONE / 8), 0, $urandom);
      end
    endcase
    return q;
  endfunction

  task automatic write_threshold(logic [qov_pkg::THR_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    det_thr = value;
  endtask

  task automatic drain_all();
    @(negedge clk);
    quad_ch.valid = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    // results come in order, so the pipe is empty now; settle anyway
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_quad(quadric_t q, bit typed, vertex_t v);
    @(negedge clk);
    quad_ch.valid = 1'b1;
    {quad_ch.q00, quad_ch.q01, quad_ch.q02, quad_ch.q03, quad_ch.q11,
     quad_ch.q12, quad_ch.q13, quad_ch.q22, quad_ch.q23, quad_ch.q33} = q;
    do @(posedge clk); while (!quad_ch.ready);
    pending_vertices.push_back(typed ? v : solve_vertex(q, det_thr));
  endtask

  task automatic maybe_gap();
    int n;
    if (calm || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 8);
    @(negedge clk);
    quad_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      maybe_gap();
      send_quad(rand_quad(), 1'b0, '0);
    end
  endtask

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    int n;
    vertex_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        vertex_ch.ready = 1'b0;
        repeat (200) @(negedge clk);
        hold_req = 1'b0;
        vertex_ch.ready = 1'b1;
      end else if (calm) begin
        vertex_ch.ready = 1'b1;
      end else begin
        n = $urandom_range(1, 8);
        vertex_ch.ready = ($urandom_range(0, 2) != 0);
        repeat (n - 1) begin
          @(negedge clk);
          if (hold_req || calm) break;
        end
      end
    end
  end

  always @(posedge clk) begin
    vertex_t got, want;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && vertex_ch.valid && vertex_ch.ready) begin
      got = {vertex_ch.solved, vertex_ch.pos_x, vertex_ch.pos_y, vertex_ch.pos_z,
             vertex_ch.quad_error};
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex result %h", $time, got);
        errors++;
      end else begin
        want = pending_vertices.pop_front();
        if (got.solved !== want.solved) begin
          $display("%0t: solved exp %0b got %0b", $time, want.solved, got.solved);
          errors++;
        end
        if (got.pos_x !== want.pos_x) begin
          $display("%0t: pos_x exp %h got %h", $time, want.pos_x, got.pos_x);
          errors++;
        end
        if (got.pos_y !== want.pos_y) begin
          $display("%0t: pos_y exp %h got %h", $time, want.pos_y, got.pos_y);
          errors++;
        end
        if (got.pos_z !== want.pos_z) begin
          $display("%0t: pos_z exp %h got %h", $time, want.pos_z, got.pos_z);
          errors++;
        end
        if (got.quad_error !== want.quad_error) begin
          $display("%0t: quad_error exp %h got %h", $time, want.quad_error,
                   got.quad_error);
          errors++;
        end
      end
    end
  end

  initial begin
    quad_row_t rows[$];
    quad_row_t r;
    vertex_t zero_v;
    zero_v = '0;
    quad_ch.valid = 1'b0;
    {quad_ch.q00, quad_ch.q01, quad_ch.q02, quad_ch.q03, quad_ch.q11,
     quad_ch.q12, quad_ch.q13, quad_ch.q22, quad_ch.q23, quad_ch.q33} = '0;

    // all zero: singular
    r.q = '0; r.typed = 1; r.v = zero_v; rows.push_back(r);
    // unit A, no linear term: vertex at the origin, error zero
    r.q = mk_quad(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, 0); r.typed = 1;
    r.v = '{1'b1, 32'sd0, 32'sd0, 32'sd0, 48'sd0}; rows.push_back(r);
    // det = 1 raw, below the reset threshold
    r.q = mk_quad(1, 1, 1, ONE, ONE, ONE, 0, 0, 0, ONE); r.typed = 1; r.v = zero_v;
    rows.push_back(r);
    // rank-deficient A with every entry one
    r.q = mk_quad(ONE, ONE, ONE, ONE, 0, 0, ONE, ONE, ONE, 0); r.typed = 1; r.v = zero_v;
    rows.push_back(r);
    r.typed = 0;
    r.q = mk_quad(ONE, ONE, ONE, -ONE, 2 * ONE, -3 * ONE, 0, 0, 0, 5 * ONE);
    rows.push_back(r);
    r.q = mk_quad(2 * ONE, 3 * ONE, 5 * ONE, ONE, -ONE, ONE / 2, ONE / 2, -ONE / 4,
                  ONE / 8, -ONE);
    rows.push_back(r);
    r.q = {10{32'sh7fffffff}}; rows.push_back(r);
    r.q = {10{32'sh80000000}}; rows.push_back(r);
    r.q = mk_quad(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh80000000, 32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000, 1);
    rows.push_back(r);
    // tiny diagonal: determinant below the reset threshold, so the solve fails
    r.q = mk_quad(ONE / 256, ONE / 256, ONE / 256, 32'sh80000000, 32'sh7fffffff,
                  32'sh80000000, 0, 0, 0, 32'sh7fffffff);
    rows.push_back(r);
    // extreme diagonal and linear entries: coordinates near one
    r.q = mk_quad(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                  32'sh80000000, 32'sh80000000, 0, 0, 0, 32'sh7fffffff);
    rows.push_back(r);
    // rounding ties: x = -b/a with half-ulp remainders
    r.q = mk_quad(2 * ONE, 2 * ONE, 2 * ONE, 1, -1, 3, 0, 0, 0, -1); rows.push_back(r);
    r.q = mk_quad(-ONE, 7 * ONE, -3 * ONE, 5, 7, -9, ONE, -ONE, ONE, 0);
    rows.push_back(r);
    r.q = mk_quad(-1, -1, -1, -1, -1, -1, 0, 0, 0, -1); rows.push_back(r);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_quad(rows[i].q, rows[i].typed, rows[i].v);
    drain_all();

    // threshold zero: only an exactly singular A fails
    write_threshold('0);
    r.q = mk_quad(1, 1, 1, ONE, ONE, ONE, 0, 0, 0, ONE);
    send_quad(r.q, 1'b0, zero_v);
    r.q = '0; send_quad(r.q, 1'b1, zero_v);
    random_phase(90);

    // long receiver stall while requests keep coming
    hold_req = 1'b1;
    random_phase(80);
    drain_all();

    write_threshold('1);
    random_phase(70);
    drain_all();

    write_threshold(qov_pkg::THR_W'(ONE));
    random_phase(70);
    drain_all();

    write_threshold($urandom_range(0, 64));
    random_phase(60);
    drain_all();

    calm = 1'b1;
    write_threshold(qov_pkg::THR_RESET);
    random_phase(60);
    drain_all();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
